// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Implication or plain property, checked on every rising edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== hdl/lpwh_pkg.sv =====
// ----------------------------------------------------------------------------
// lpwh_pkg
// Shared types, codes and constants of the linear-probe word hash table.
// ----------------------------------------------------------------------------
package lpwh_pkg;

    // Default log2 of the slot memory depth
    localparam int DEF_TABLE_LOG  = 10;
    // Widest home slot carried between front and back (parameter range top)
    localparam int ADDR_MAX_W     = 16;
    // Characters per word at most, and key width
    localparam int MAX_WORD_CHARS = 8;
    localparam int KEY_W          = 64;
    // Configuration word width and index width
    localparam int CFG_W          = 4;
    localparam int CFG_IDX_W      = 1;
    // Effective log and length widths
    localparam int LOG_W          = 5;
    localparam int LEN_W          = 4;
    // Character sum width (eight bytes)
    localparam int SUM_W          = 11;
    // Result slot field width
    localparam int SLOT_W         = 10;

    // Register reset values
    localparam logic [CFG_W-1:0] CFG_LOG_RESET = 4'd10;
    localparam logic [CFG_W-1:0] CFG_LEN_RESET = 4'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LOG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_LEN  = 1'b1;

    // Operation codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_STORED  = 2'd0,
        ST_DROPPED = 2'd1,
        ST_FOUND   = 2'd2,
        ST_ABSENT  = 2'd3
    } t_status;

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] key;
    } t_in;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
    } t_out;

    // Classified job handed from front to back
    typedef struct packed {
        logic                  mode;
        logic [KEY_W-1:0]      key;
        logic [ADDR_MAX_W-1:0] home;
    } t_job;

    // Effective (saturated) configuration
    typedef struct packed {
        logic [LOG_W-1:0] lg;
        logic [LEN_W-1:0] len;
    } t_cfg;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_FETCH,
        B_CHECK,
        B_DONE
    } t_bstate;

endpackage

// ===== hdl/lpwh_fifo.sv =====
// ----------------------------------------------------------------------------
// lpwh_fifo
// Small register queue, push/full on one side and pop/empty on the other.
// ----------------------------------------------------------------------------
module lpwh_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hdl/lpwh_front.sv =====
// ----------------------------------------------------------------------------
// lpwh_front
// Accepts a word, computes its home slot one character per cycle and queues
// the classified job for the probe engine.
// ----------------------------------------------------------------------------
module lpwh_front #(
    parameter int MAX_TABLE_LOG = lpwh_pkg::DEF_TABLE_LOG
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lpwh_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    input  lpwh_pkg::t_in  i_data,
    output logic           o_busy,
    output logic           o_push,
    output lpwh_pkg::t_job o_job,
    input  logic           i_full
);

    import lpwh_pkg::*;

    localparam int ADDR_W = MAX_TABLE_LOG;

    t_fstate            r_state, n_state;
    logic               r_mode;
    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   r_sh, n_sh;
    logic [ADDR_W-1:0]  r_h, n_h;
    logic [ADDR_W-1:0]  r_s, n_s;
    logic [LEN_W-1:0]   r_ci, n_ci;
    logic [ADDR_W-1:0]  w_smask;
    logic [SUM_W-1:0]   w_sum;
    logic [7:0]         w_c;
    logic [ADDR_W+7:0]  w_prod;
    logic [ADDR_W-1:0]  w_home;
    logic               w_accept;

    assign o_busy   = (r_state != F_IDLE);
    assign w_accept = i_valid && (r_state == F_IDLE);

    // slot mask from the effective log
    always_comb begin
        for (int i = 0; i < ADDR_W; i++) begin
            w_smask[i] = (LOG_W'(i) < i_cfg.lg);
        end
    end

    // character sum over the active length
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < MAX_WORD_CHARS; i++) begin
            if (LEN_W'(i) < i_cfg.len) begin
                w_sum = w_sum + SUM_W'(i_data.key[8*i +: 8]);
            end
        end
    end

    // one hash step: h*c + c
    assign w_c    = r_sh[7:0];
    assign w_prod = {8'd0, r_h} * {{ADDR_W{1'b0}}, w_c} + {{ADDR_W{1'b0}}, w_c};
    assign w_home = (r_h - r_s) & w_smask;

    assign o_job.mode = r_mode;
    assign o_job.key  = r_key;
    assign o_job.home = ADDR_MAX_W'(w_home);

    // state register and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh <= n_sh;
        r_h  <= n_h;
        r_s  <= n_s;
        r_ci <= n_ci;
        if (w_accept) begin
            r_mode <= i_data.mode;
            r_key  <= i_data.key;
        end
    end

    // next state and outputs
    always_comb begin
        n_state = r_state;
        n_sh    = r_sh;
        n_h     = r_h;
        n_s     = r_s;
        n_ci    = r_ci;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_sh    = i_data.key;
                    n_s     = ADDR_W'(w_sum) & w_smask;
                    n_h     = ADDR_W'(w_sum) & w_smask;
                    n_ci    = '0;
                    n_state = F_HASH;
                end
            end
            F_HASH: begin
                n_h  = w_prod[ADDR_W-1:0] & w_smask;
                n_sh = {8'd0, r_sh[KEY_W-1:8]};
                n_ci = r_ci + LEN_W'(1);
                if (r_ci == i_cfg.len - LEN_W'(1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/lpwh_back.sv =====
// ----------------------------------------------------------------------------
// lpwh_back
// Probe engine: owns the slot memories, clears the used bits after reset and
// walks slots from the home slot to store or find a word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpwh_back #(
    parameter int MAX_TABLE_LOG = lpwh_pkg::DEF_TABLE_LOG
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lpwh_pkg::t_cfg i_cfg,
    input  lpwh_pkg::t_job i_job,
    input  logic           i_job_empty,
    output logic           o_job_pop,
    output lpwh_pkg::t_out o_res,
    output logic           o_res_push,
    input  logic           i_res_full,
    output logic           o_clearing
);

    import lpwh_pkg::*;

    localparam int ADDR_W = MAX_TABLE_LOG;
    localparam int DEPTH  = 1 << ADDR_W;

    // slot memories
    logic             m_used [DEPTH];
    logic [KEY_W-1:0] m_word [DEPTH];

    t_bstate           r_state, n_state;
    logic [ADDR_W-1:0] r_clr;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [ADDR_W:0]   r_n, n_n;
    logic              r_mode;
    logic [KEY_W-1:0]  r_key;
    t_out              r_res, n_res;
    logic              r_used_q;
    logic [KEY_W-1:0]  r_word_q;
    logic [ADDR_W-1:0] w_smask;
    logic [ADDR_W:0]   w_size;
    logic [KEY_W-1:0]  w_cmask;
    logic              w_match;
    logic              w_used_we;
    logic [ADDR_W-1:0] w_used_addr;
    logic              w_used_data;
    logic              w_word_we;

    assign o_clearing = (r_state == B_CLEAR);
    assign o_res      = r_res;

    // masks from the effective configuration
    always_comb begin
        for (int i = 0; i < ADDR_W; i++) begin
            w_smask[i] = (LOG_W'(i) < i_cfg.lg);
        end
        for (int i = 0; i <= ADDR_W; i++) begin
            w_size[i] = (LOG_W'(i) == i_cfg.lg);
        end
        for (int i = 0; i < MAX_WORD_CHARS; i++) begin
            w_cmask[8*i +: 8] = {8{LEN_W'(i) < i_cfg.len}};
        end
    end

    assign w_match = (((r_word_q ^ r_key) & w_cmask) == '0);

    // memory write port: clearing pass or insert
    assign w_used_we   = (r_state == B_CLEAR) || w_word_we;
    assign w_used_addr = (r_state == B_CLEAR) ? r_clr : r_idx;
    assign w_used_data = (r_state != B_CLEAR);
    assign w_word_we   = (r_state == B_CHECK) && !r_used_q && (r_mode == MODE_INSERT);

    always_ff @(posedge i_clk) begin
        if (w_used_we) begin
            m_used[w_used_addr] <= w_used_data;
        end
        if (w_word_we) begin
            m_word[r_idx] <= r_key;
        end
        r_used_q <= m_used[r_idx];
        r_word_q <= m_word[r_idx];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_clr   <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            if (r_state == B_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
        end
    end

    // job and result registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_res <= n_res;
        if (o_job_pop) begin
            r_mode <= i_job.mode;
            r_key  <= i_job.key;
        end
    end

    // next state and outputs
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_n        = r_n;
        n_res      = r_res;
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            B_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_idx     = ADDR_W'(i_job.home);
                    n_n       = '0;
                    n_state   = B_FETCH;
                end
            end
            B_FETCH: begin
                n_state = B_CHECK;
            end
            B_CHECK: begin
                if (!r_used_q) begin
                    // empty slot ends both kinds of walk
                    if (r_mode == MODE_INSERT) begin
                        n_res.status = ST_STORED;
                        n_res.slot   = SLOT_W'(r_idx);
                    end else begin
                        n_res.status = ST_ABSENT;
                        n_res.slot   = '0;
                    end
                    n_state = B_DONE;
                end else if ((r_mode == MODE_LOOKUP) && w_match) begin
                    n_res.status = ST_FOUND;
                    n_res.slot   = SLOT_W'(r_idx);
                    n_state      = B_DONE;
                end else if (r_n + (ADDR_W+1)'(1) == w_size) begin
                    // full wrap
                    n_res.status = (r_mode == MODE_INSERT) ? ST_DROPPED : ST_ABSENT;
                    n_res.slot   = '0;
                    n_state      = B_DONE;
                end else begin
                    n_n     = r_n + (ADDR_W+1)'(1);
                    n_idx   = (r_idx + ADDR_W'(1)) & w_smask;
                    n_state = B_FETCH;
                end
            end
            B_DONE: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // checks
    `ASSERT_CLK(a_check_after_fetch, i_clk, i_rst_n,
        (r_state == B_CHECK) |-> ($past(r_state) == B_FETCH),
        "slot check without a preceding fetch")
    `ASSERT_CLK(a_probe_in_range, i_clk, i_rst_n,
        ((r_state == B_FETCH) || (r_state == B_CHECK)) |-> (r_n < w_size),
        "probe count beyond table size")
    `ASSERT_CLK(a_stored_is_insert, i_clk, i_rst_n,
        ((r_state == B_DONE) && (r_res.status == ST_STORED)) |-> (r_mode == MODE_INSERT),
        "stored result for a lookup")

endmodule

// ===== hdl/linear_probe_word_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// linear_probe_word_hash_table_core
// Open-addressing word hash table with linear probing, insert and lookup.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the used bits; full stays
// high until it is done. A word is hashed in the front at one character per
// cycle (one multiply per step), and the front accepts the next word while
// the probe engine works. The probe engine visits each slot with a fetch and
// a check (registered memory read, then compare), after it picks up the job
// and before it delivers the result. A two-word queue sits between front and
// back and another on the result side. Configuration registers: index 0
// table_size_log, index 1 word_length; write them only while the block is
// idle.
module linear_probe_word_hash_table_core #(
    parameter int MAX_TABLE_LOG = lpwh_pkg::DEF_TABLE_LOG
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    input  lpwh_pkg::t_in                  i_in,
    output logic                           full,
    output logic                           empty,
    input  logic                           pop,
    output lpwh_pkg::t_out                 o_out,
    input  logic                           i_cfg_we,
    input  logic [lpwh_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [lpwh_pkg::CFG_W-1:0]     i_cfg_wdata
);

    import lpwh_pkg::*;

    localparam int JOB_W = $bits(t_job);
    localparam int OUT_W = $bits(t_out);

    logic [CFG_W-1:0] r_cfg_log;
    logic [CFG_W-1:0] r_cfg_len;
    t_cfg             w_cfg;
    logic             w_front_busy;
    logic             w_clearing;
    logic             w_job_push;
    t_job             w_job_in;
    logic [JOB_W-1:0] w_job_vec;
    logic             w_job_full;
    logic             w_job_empty;
    logic             w_job_pop;
    t_out             w_res;
    logic             w_res_push;
    logic             w_res_full;
    logic [OUT_W-1:0] w_out_vec;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_log <= CFG_LOG_RESET;
            r_cfg_len <= CFG_LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TABLE_LOG: r_cfg_log <= i_cfg_wdata;
                CFG_WORD_LEN:  r_cfg_len <= i_cfg_wdata;
                default:       ;
            endcase
        end
    end

    // saturate to the supported ranges
    always_comb begin
        if (r_cfg_log == '0) begin
            w_cfg.lg = LOG_W'(1);
        end else if (LOG_W'(r_cfg_log) > LOG_W'(MAX_TABLE_LOG)) begin
            w_cfg.lg = LOG_W'(MAX_TABLE_LOG);
        end else begin
            w_cfg.lg = LOG_W'(r_cfg_log);
        end
        if (r_cfg_len == '0) begin
            w_cfg.len = LEN_W'(1);
        end else if (LEN_W'(r_cfg_len) > LEN_W'(MAX_WORD_CHARS)) begin
            w_cfg.len = LEN_W'(MAX_WORD_CHARS);
        end else begin
            w_cfg.len = LEN_W'(r_cfg_len);
        end
    end

    assign full = w_front_busy || w_clearing;

    // front: accept and hash
    lpwh_front #(
        .MAX_TABLE_LOG(MAX_TABLE_LOG)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (push && !w_clearing),
        .i_data  (i_in),
        .o_busy  (w_front_busy),
        .o_push  (w_job_push),
        .o_job   (w_job_in),
        .i_full  (w_job_full)
    );

    // job queue between front and back
    lpwh_fifo #(
        .W     (JOB_W),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_data  (w_job_vec),
        .o_empty (w_job_empty)
    );

    // back: probe engine and slot memories
    lpwh_back #(
        .MAX_TABLE_LOG(MAX_TABLE_LOG)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_job       (t_job'(w_job_vec)),
        .i_job_empty (w_job_empty),
        .o_job_pop   (w_job_pop),
        .o_res       (w_res),
        .o_res_push  (w_res_push),
        .i_res_full  (w_res_full),
        .o_clearing  (w_clearing)
    );

    // result queue
    lpwh_fifo #(
        .W     (OUT_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_out_vec),
        .o_empty (empty)
    );

    assign o_out = t_out'(w_out_vec);

endmodule
